// File: rtl/rrw_pkg.sv
package rrw_pkg;

  // Width of every timestamp and time interval.
  localparam int unsigned TimeW  = 32;
  // Width of the reload counter.
  localparam int unsigned CountW = 8;
  // Width of the max_fast_reloads register.
  localparam int unsigned MaxW   = 8;
  // Width used when the counter is compared with the maximum.
  localparam int unsigned CmpW   = (CountW > MaxW) ? CountW : MaxW;

  // APB-side register map.
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  typedef logic [TimeW-1:0]  time_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [MaxW-1:0]   max_t;
  typedef logic [CmpW-1:0]   cmp_t;

  typedef enum logic [1:0] {
    ActLinkChange = 2'd0,
    ActNetReturn  = 2'd1,
    ActQuery      = 2'd2,
    ActReloadDone = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    RegGrace    = 2'd0,
    RegMaxFast  = 2'd1,
    RegCooldown = 2'd2,
    RegSlow     = 2'd3
  } reg_idx_e;

  localparam time_t  GraceRst    = time_t'(10000);
  localparam max_t   MaxFastRst  = max_t'(3);
  localparam time_t  CooldownRst = time_t'(30000);
  localparam time_t  SlowRst     = time_t'(300000);
  localparam count_t CountMax    = {CountW{1'b1}};

  // True when at least span has passed from then_v to now_v; a time that
  // went backward counts as not yet passed.
  function automatic logic elapsed(input time_t now_v, input time_t then_v,
                                   input time_t span);
    logic [TimeW:0] diff;
    diff = {1'b0, now_v} - {1'b0, then_v};
    return !diff[TimeW] && (diff[TimeW-1:0] >= span);
  endfunction

endpackage

// File: rtl/rrw_in_if.sv
interface rrw_in_if;
  import rrw_pkg::*;

  logic       valid;
  logic       ready;
  action_e    action;
  logic       link_up;
  time_t      now_ms;

  modport source (output valid, action, link_up, now_ms, input ready);
  modport sink   (input valid, action, link_up, now_ms, output ready);
endinterface

// File: rtl/rrw_out_if.sv
interface rrw_out_if;
  logic valid;
  logic ready;
  logic reload_due;
  logic link_connected;

  modport source (output valid, reload_due, link_connected, input ready);
  modport sink   (input valid, reload_due, link_connected, output ready);
endinterface

// File: rtl/reconnect_retry_watchdog.sv
// Path: an accepted input transfer is held in the input register, and its result is then
// registered into the result register, from which it is offered on out_o.
// Throughput: one event per cycle; the input register and the result register
// each advance whenever the result register is empty or is being taken.
// Reset (rst_ni low, asynchronous): link connected, no outage, no reload seen,
// reload count zero, configuration registers back to their defaults.
module reconnect_retry_watchdog (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rrw_in_if.sink                in_i,
  rrw_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [rrw_pkg::AddrW-1:0] paddr,
  input  logic [rrw_pkg::DataW-1:0] pwdata,
  output logic [rrw_pkg::DataW-1:0] prdata,
  output logic                  pready
);
  import rrw_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers. Writes complete in the APB access phase; the
  // port never inserts wait states.
  // ---------------------------------------------------------------------
  time_t grace_q, cooldown_q, slow_q;
  max_t  max_fast_q;
  logic  cfg_we;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grace_q    <= GraceRst;
      max_fast_q <= MaxFastRst;
      cooldown_q <= CooldownRst;
      slow_q     <= SlowRst;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegGrace:    grace_q    <= pwdata[TimeW-1:0];
        RegMaxFast:  max_fast_q <= pwdata[MaxW-1:0];
        RegCooldown: cooldown_q <= pwdata[TimeW-1:0];
        RegSlow:     slow_q     <= pwdata[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      RegGrace:    prdata = DataW'(grace_q);
      RegMaxFast:  prdata = DataW'(max_fast_q);
      RegCooldown: prdata = DataW'(cooldown_q);
      RegSlow:     prdata = DataW'(slow_q);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input register. An event sits here while its effect on the watchdog state
  // and its result are computed. Both the stage and the result register move
  // together, so back-to-back events see each other's state updates without
  // any forwarding.
  // ---------------------------------------------------------------------
  logic    s1_valid_q;
  action_e s1_action_q;
  logic    s1_up_q;
  time_t   s1_now_q;
  logic    out_valid_q, out_due_q, out_conn_q;
  logic    advance;

  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_action_q <= in_i.action;
      s1_up_q     <= in_i.link_up;
      s1_now_q    <= in_i.now_ms;
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog state and the per-event update.
  // ---------------------------------------------------------------------
  logic   conn_q, conn_d;
  logic   outage_valid_q, outage_valid_d;
  time_t  outage_start_q, outage_start_d;
  count_t count_q, count_d;
  logic   last_valid_q, last_valid_d;
  time_t  last_time_q, last_time_d;
  logic   due_d;
  cmp_t   eff_max;
  logic   fast_used;
  time_t  interval;

  // A maximum of zero behaves as one.
  assign eff_max   = (max_fast_q == '0) ? cmp_t'(1) : cmp_t'(max_fast_q);
  assign fast_used = cmp_t'(count_q) >= eff_max;
  assign interval  = fast_used ? slow_q : cooldown_q;

  always_comb begin
    conn_d         = conn_q;
    outage_valid_d = outage_valid_q;
    outage_start_d = outage_start_q;
    count_d        = count_q;
    last_valid_d   = last_valid_q;
    last_time_d    = last_time_q;
    due_d          = 1'b0;
    case (s1_action_q)
      ActLinkChange: begin
        if (s1_up_q != conn_q) begin
          conn_d = s1_up_q;
          if (s1_up_q) begin
            // Reconnect wipes the outage and the reload history.
            outage_valid_d = 1'b0;
            outage_start_d = '0;
            count_d        = '0;
            last_valid_d   = 1'b0;
            last_time_d    = '0;
          end else begin
            outage_valid_d = 1'b1;
            outage_start_d = s1_now_q;
          end
        end
      end
      ActNetReturn: begin
        if (!conn_q) begin
          // Backdate the outage so the grace time is already spent. If that
          // would land before time zero, the outage start is dropped.
          if (s1_now_q >= grace_q) begin
            outage_valid_d = 1'b1;
            outage_start_d = s1_now_q - grace_q;
          end else begin
            outage_valid_d = 1'b0;
            outage_start_d = '0;
          end
          // Leave at least one fast attempt available: a used-up count drops to one below the maximum.
          if (fast_used) begin
            count_d = count_t'(eff_max - cmp_t'(1));
          end
        end
      end
      ActQuery: begin
        if (!conn_q && outage_valid_q && elapsed(s1_now_q, outage_start_q, grace_q)) begin
          due_d = !last_valid_q || elapsed(s1_now_q, last_time_q, interval);
        end
      end
      ActReloadDone: begin
        if (count_q != CountMax) begin
          count_d = count_q + count_t'(1);
        end
        last_valid_d   = 1'b1;
        last_time_d    = s1_now_q;
        outage_valid_d = 1'b1;
        outage_start_d = s1_now_q;
      end
      default: ;
    endcase
  end

  logic step;
  assign step = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q         <= 1'b1;
      outage_valid_q <= 1'b0;
      outage_start_q <= '0;
      count_q        <= '0;
      last_valid_q   <= 1'b0;
      last_time_q    <= '0;
    end else if (step) begin
      conn_q         <= conn_d;
      outage_valid_q <= outage_valid_d;
      outage_start_q <= outage_start_d;
      count_q        <= count_d;
      last_valid_q   <= last_valid_d;
      last_time_q    <= last_time_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register. It holds a finished result while the sink stalls, and
  // the input register keeps accepting as long as it has room.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_due_q  <= due_d;
      out_conn_q <= conn_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.reload_due     = out_due_q;
  assign out_o.link_connected = out_conn_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // A reload is never requested while the link is reported connected.
  a_due_only_when_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.reload_due |-> !out_o.link_connected)
    else $error("reload_due raised while link connected");

  // An input transfer never lands on an occupied stage that is not moving.
  a_no_stage_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |-> !s1_valid_q || advance)
    else $error("input transfer overwrote a pending event");

  // A stalled result is not replaced by the next event.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_due_q)
      && $stable(out_conn_q) && $stable(conn_q))
    else $error("result register or state changed during a stall");
endmodule
